/* sv/assert_macros.svh */
// Assertion helpers for the band energy evaluator.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Implication whose consequent is checked in the next cycle.
`define ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

// Implication checked in the same cycle.
`define ASSERT_SAME(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

`endif

/* sv/gbe_pkg.sv */
package gbe_pkg;

    localparam int CORDIC_STEPS = 20;
    localparam int CSTEPS = (CORDIC_STEPS > 32) ? 32 : CORDIC_STEPS;

    localparam logic [31:0] SQRT3_HALF_Q32 = 32'd3719550787;
    localparam logic [30:0] HALF_PI_Q30 = 31'd1686629713;
    localparam logic signed [33:0] CORDIC_GAIN_Q30 = 34'sd652032874;
    localparam logic [19:0] HOP_RESET = 20'd198771;
    localparam logic [22:0] ENERGY_MAX = 23'd4194303;

    // Register stages from request to result: phase, cosine load and rotations,
    // product and radicand, root load and bits, scaling and output.
    localparam int SQRT_STEPS = 32;
    localparam int LATENCY = 1 + (CSTEPS + 1) + 2 + (SQRT_STEPS + 1) + 2;

    // Arctangent table in Q0.30, one entry per CORDIC step.
    function automatic logic [29:0] atan_q30(input int i);
        logic [29:0] v;
        case (i)
            0: v = 30'd843314857;
            1: v = 30'd497837829;
            2: v = 30'd263043837;
            3: v = 30'd133525159;
            4: v = 30'd67021687;
            5: v = 30'd33543516;
            6: v = 30'd16775851;
            7: v = 30'd8388437;
            8: v = 30'd4194283;
            9: v = 30'd2097149;
            31: v = 30'd0;
            default: v = 30'd1 << (30 - i);
        endcase
        return v;
    endfunction

    // Status that travels along with each request.
    typedef struct packed {
        logic valid;
        logic clamped;
    } t_tag;

endpackage

/* sv/gbe_cordic.sv */
module gbe_cordic import gbe_pkg::*; (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_valid,
    input  logic [31:0]         i_turn,
    output logic                o_valid,
    output logic signed [33:0]  o_cos
);

    logic              r_v    [0:CSTEPS];
    logic signed [33:0] r_x   [0:CSTEPS];
    logic signed [33:0] r_y   [0:CSTEPS];
    logic signed [33:0] r_z   [0:CSTEPS];
    logic              r_flip [0:CSTEPS];

    logic [31:0]        n_u;
    logic               n_flip;
    logic signed [64:0] n_prod;

    // Fold the angle into a quarter turn either side of zero, then scale to radians.
    always_comb begin
        n_flip = i_turn[31] ^ i_turn[30];
        n_u    = n_flip ? (i_turn + 32'h8000_0000) : i_turn;
        n_prod = $signed(n_u) * $signed({1'b0, HALF_PI_Q30});
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v[0] <= 1'b0;
        end else begin
            r_v[0] <= i_valid;
        end
        r_x[0]    <= CORDIC_GAIN_Q30;
        r_y[0]    <= '0;
        r_z[0]    <= 34'(n_prod >>> 30);
        r_flip[0] <= n_flip;
    end

    // One rotation per stage.
    for (genvar g = 0; g < CSTEPS; g++) begin : g_step
        always_ff @(posedge i_clk) begin
            if (!i_rst_n) begin
                r_v[g+1] <= 1'b0;
            end else begin
                r_v[g+1] <= r_v[g];
            end
            r_flip[g+1] <= r_flip[g];
            if (!r_z[g][33]) begin
                r_x[g+1] <= r_x[g] - (r_y[g] >>> g);
                r_y[g+1] <= r_y[g] + (r_x[g] >>> g);
                r_z[g+1] <= r_z[g] - $signed({4'd0, atan_q30(g)});
            end else begin
                r_x[g+1] <= r_x[g] + (r_y[g] >>> g);
                r_y[g+1] <= r_y[g] - (r_x[g] >>> g);
                r_z[g+1] <= r_z[g] + $signed({4'd0, atan_q30(g)});
            end
        end
    end

    assign o_valid = r_v[CSTEPS];
    assign o_cos   = r_flip[CSTEPS] ? -r_x[CSTEPS] : r_x[CSTEPS];

endmodule

/* sv/gbe_sqrt.sv */
module gbe_sqrt import gbe_pkg::*; (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  t_tag        i_tag,
    input  logic [63:0] i_rad,
    output t_tag        o_tag,
    output logic [31:0] o_root
);

    // Restoring square root, one result bit per stage.
    t_tag        r_tag [0:SQRT_STEPS];
    logic [63:0] r_rem [0:SQRT_STEPS];
    logic [31:0] r_q   [0:SQRT_STEPS];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_tag[0] <= '0;
        end else begin
            r_tag[0] <= i_tag;
        end
        r_rem[0] <= i_rad;
        r_q[0]   <= '0;
    end

    for (genvar g = 0; g < SQRT_STEPS; g++) begin : g_bit
        localparam int B = SQRT_STEPS - 1 - g;
        logic [64:0] n_trial;
        logic [64:0] n_cand;
        always_comb begin
            n_cand  = 65'(r_q[g]) << (B + 1);
            n_trial = n_cand | (65'd1 << (2 * B));
        end
        always_ff @(posedge i_clk) begin
            if (!i_rst_n) begin
                r_tag[g+1] <= '0;
            end else begin
                r_tag[g+1] <= r_tag[g];
            end
            if ({1'b0, r_rem[g]} >= n_trial) begin
                r_rem[g+1] <= 64'({1'b0, r_rem[g]} - n_trial);
                r_q[g+1]   <= r_q[g] | (32'd1 << B);
            end else begin
                r_rem[g+1] <= r_rem[g];
                r_q[g+1]   <= r_q[g];
            end
        end
    end

    assign o_tag  = r_tag[SQRT_STEPS];
    assign o_root = r_q[SQRT_STEPS];

endmodule

/* sv/graphene_band_energy_evaluator.sv */
// Graphene band energy evaluator.
// Requests: drive i_kx_scaled and i_ky_scaled with start high; a request is
// taken at every edge where start is high, since busy is always low.
// Configuration: i_cfg_valid with i_cfg_data writes the hopping energy
// (Q4.16 eV); o_cfg_ready is always high. Write it only while idle.
// Results: o_done pulses for one cycle with the conduction energy, the
// valence energy (its negation) and the radicand clamp flag.
// The pipeline has one phase stage, CORDIC_STEPS + 1 cosine stages, two
// radicand stages, 33 square root stages and two scaling stages, one
// register per rotation and root bit.
// Throughput is one request per cycle; requests in flight never block.
// Reset empties the pipeline and restores the hopping energy to 3.033 eV.
// The receiver cannot stall: each result is shown for one cycle only.
`include "assert_macros.svh"

module graphene_band_energy_evaluator import gbe_pkg::*; (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               start,
    output logic               busy,
    input  logic signed [23:0] i_kx_scaled,
    input  logic signed [23:0] i_ky_scaled,
    input  logic               i_cfg_valid,
    output logic               o_cfg_ready,
    input  logic [19:0]        i_cfg_data,
    output logic               o_done,
    output logic signed [22:0] o_conduction_energy,
    output logic signed [22:0] o_valence_energy,
    output logic               o_radicand_clamped
);

    logic [19:0] r_hop;
    logic        r_v0;
    logic [31:0] r_tx, r_ty;
    logic signed [55:0] n_kxp;

    assign busy        = 1'b0;
    assign o_cfg_ready = 1'b1;

    // Hopping energy register.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_hop <= HOP_RESET;
        end else if (i_cfg_valid) begin
            r_hop <= i_cfg_data;
        end
    end

    // Phase stage: turns for both axes.
    assign n_kxp = i_kx_scaled * $signed({1'b0, SQRT3_HALF_Q32});
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v0 <= 1'b0;
        end else begin
            r_v0 <= start;
        end
        r_tx <= n_kxp[51:20];
        r_ty <= {i_ky_scaled[20:0], 11'd0};
    end

    logic               cx_v, cy_v;
    logic signed [33:0] cx, cy;

    gbe_cordic u_cos_x (.i_clk, .i_rst_n, .i_valid(r_v0), .i_turn(r_tx),
                        .o_valid(cx_v), .o_cos(cx));
    gbe_cordic u_cos_y (.i_clk, .i_rst_n, .i_valid(r_v0), .i_turn(r_ty),
                        .o_valid(cy_v), .o_cos(cy));

    // Product stage, then radicand with clamp.
    logic               r_pv, r_rv;
    logic signed [69:0] r_prod;
    logic [63:0]        r_rad;
    logic               r_clamp;
    logic signed [42:0] n_rad;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pv <= 1'b0;
            r_rv <= 1'b0;
        end else begin
            r_pv <= cx_v;
            r_rv <= r_pv;
        end
        r_prod <= cy * (cx + cy);
    end

    // The radicand reaches about nine in Q.30, so it needs 34 bits.
    assign n_rad = 43'sd1073741824 + 43'(r_prod >>> 28);
    always_ff @(posedge i_clk) begin
        r_clamp <= n_rad[42];
        r_rad   <= n_rad[42] ? '0 : {n_rad[33:0], 30'd0};
    end

    t_tag        sq_tag;
    logic [31:0] root;

    gbe_sqrt u_sqrt (.i_clk, .i_rst_n, .i_tag('{valid: r_rv, clamped: r_clamp}),
                     .i_rad(r_rad), .o_tag(sq_tag), .o_root(root));

    // Scale by hopping energy, round, saturate.
    logic        r_sv;
    logic        r_sc;
    logic [52:0] r_e;
    logic [52:0] n_e;
    logic [22:0] n_sat;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_sv   <= 1'b0;
            o_done <= 1'b0;
        end else begin
            r_sv   <= sq_tag.valid;
            o_done <= r_sv;
        end
        r_sc <= sq_tag.clamped;
        r_e  <= 53'(r_hop) * 53'(root) + 53'd536870912;
    end

    assign n_e   = r_e >> 30;
    assign n_sat = (n_e > 53'(ENERGY_MAX)) ? ENERGY_MAX : n_e[22:0];

    always_ff @(posedge i_clk) begin
        o_conduction_energy <= $signed(n_sat);
        o_valence_energy    <= -$signed(n_sat);
        o_radicand_clamped  <= r_sc;
    end

    `ASSERT_NEXT(a_start_flows, i_clk, i_rst_n, start, r_v0, "request lost at entry")
    `ASSERT_SAME(a_both_cos, i_clk, i_rst_n, cx_v, cy_v, "cosine lanes out of step")
    `ASSERT_SAME(a_nonneg, i_clk, i_rst_n, o_done, !o_conduction_energy[22],
                 "negative conduction energy")
    `ASSERT_SAME(a_clamp_zero, i_clk, i_rst_n, o_done && o_radicand_clamped,
                 o_conduction_energy == 23'sd0, "clamped radicand gave nonzero energy")

endmodule
